/* rtl/jshc_pkg.sv */
// Package for the joystick scroll HID conditioner: register indexes,
// reset values, default widths and fixed thresholds.
// No dependencies.
package jshc_pkg;

  localparam int unsigned ADC_BITS_DEF    = 12;
  localparam int unsigned TIME_BITS_DEF   = 32;
  localparam int unsigned MACRO_COUNT_DEF = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned INTV_W     = 24;
  localparam int unsigned DIV_W      = 12;

  localparam int unsigned DEADZONE    = 10;
  localparam int unsigned PAN_DIVIDER = 1500;

  localparam logic [INTV_W-1:0] INTERVAL_SLOW_RST   = 24'd200000;
  localparam logic [INTV_W-1:0] INTERVAL_MEDIUM_RST = 24'd90000;
  localparam logic [INTV_W-1:0] INTERVAL_FAST_RST   = 24'd30000;
  localparam logic [DIV_W-1:0]  DIVIDER_SLOW_RST    = 12'd1500;
  localparam logic [DIV_W-1:0]  DIVIDER_MEDIUM_RST  = 12'd1500;
  localparam logic [DIV_W-1:0]  DIVIDER_FAST_RST    = 12'd1000;
  localparam logic [INTV_W-1:0] PAN_INTERVAL_RST    = 24'd90000;
  localparam logic [INTV_W-1:0] PROFILE_LOCKOUT_RST = 24'd200000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL_SLOW   = 3'd0,
    CFG_INTERVAL_MEDIUM = 3'd1,
    CFG_INTERVAL_FAST   = 3'd2,
    CFG_DIVIDER_SLOW    = 3'd3,
    CFG_DIVIDER_MEDIUM  = 3'd4,
    CFG_DIVIDER_FAST    = 3'd5,
    CFG_PAN_INTERVAL    = 3'd6,
    CFG_PROFILE_LOCKOUT = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PROFILE_SLOW   = 2'd0,
    PROFILE_MEDIUM = 2'd1,
    PROFILE_FAST   = 2'd2
  } profile_e;

  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

endpackage

/* rtl/joystick_scroll_hid_conditioner.sv */
// Joystick scroll HID conditioner: one sample per cycle in, one report out.
// Output: the report is registered and valid in the cycle after the sample is accepted.
// Throughput: one sample per cycle; a new sample enters in the cycle the previous
// report leaves, so only a stalled full output holds input.
// Reset: asynchronous, active low; clears profile, timers, sent copies and
// output valid, and loads the register reset values.
// Depends on jshc_pkg.
module joystick_scroll_hid_conditioner #(
  parameter int unsigned ADC_BITS    = jshc_pkg::ADC_BITS_DEF,
  parameter int unsigned TIME_BITS   = jshc_pkg::TIME_BITS_DEF,
  parameter int unsigned MACRO_COUNT = jshc_pkg::MACRO_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [jshc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [jshc_pkg::CFG_DATA_W-1:0] cfg_data_i,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           profile_button_i,
  input  logic                           left_button_i,
  input  logic                           right_button_i,
  input  logic [MACRO_COUNT-1:0]         macro_buttons_i,
  input  logic [ADC_BITS-1:0]            joystick_x_i,
  input  logic [ADC_BITS-1:0]            joystick_y_i,
  input  logic [TIME_BITS-1:0]           time_us_i,
  input  logic                           host_ready_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           report_send_o,
  output logic [1:0]                     report_buttons_o,
  output logic signed [1:0]              report_wheel_o,
  output logic signed [1:0]              report_pan_o,
  output logic [MACRO_COUNT-1:0]         macro_fire_o,
  output logic [1:0]                     active_profile_o
);
  import jshc_pkg::*;

  localparam int unsigned CmpW = (ADC_BITS > DIV_W) ? ADC_BITS :
                                 ((DIV_W > 11) ? DIV_W : 11);
  localparam logic [ADC_BITS:0] Centre = (ADC_BITS+1)'(1) << (ADC_BITS-1);

  logic [INTV_W-1:0] interval_q [3];
  logic [DIV_W-1:0]  divider_q [3];
  logic [INTV_W-1:0] pan_interval_q;
  logic [INTV_W-1:0] lockout_q;

  profile_e               profile_q, profile_d;
  logic                   handled_q, handled_d;
  logic [TIME_BITS-1:0]   last_prof_q, last_prof_d;
  logic [MACRO_COUNT-1:0] macro_prev_q;
  logic [TIME_BITS-1:0]   last_wheel_q, last_wheel_d;
  logic [TIME_BITS-1:0]   last_pan_q, last_pan_d;
  logic [1:0]             sent_buttons_q, sent_buttons_d;
  logic [1:0]             sent_wheel_q, sent_wheel_d;
  logic [1:0]             sent_pan_q, sent_pan_d;

  logic                   out_valid_q;
  logic                   send_q, send_d;
  logic [1:0]             buttons_q, buttons_d;
  logic [1:0]             wheel_q, wheel_d;
  logic [1:0]             pan_q, pan_d;
  logic [MACRO_COUNT-1:0] fire_q, fire_d;
  logic [1:0]             prof_out_q;

  logic                   accept;
  logic [ADC_BITS:0]      cx, cy;
  logic [ADC_BITS-1:0]    mag_x, mag_y;
  logic                   hit_x, hit_y;
  logic [1:0]             step_x, step_y;
  logic [DIV_W-1:0]       div_sel;
  logic [INTV_W-1:0]      intv_sel;
  logic [TIME_BITS-1:0]   el_prof, el_wheel, el_pan;
  logic [1:0]             raw_buttons;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q[0]  <= INTERVAL_SLOW_RST;
      interval_q[1]  <= INTERVAL_MEDIUM_RST;
      interval_q[2]  <= INTERVAL_FAST_RST;
      divider_q[0]   <= DIVIDER_SLOW_RST;
      divider_q[1]   <= DIVIDER_MEDIUM_RST;
      divider_q[2]   <= DIVIDER_FAST_RST;
      pan_interval_q <= PAN_INTERVAL_RST;
      lockout_q      <= PROFILE_LOCKOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_INTERVAL_SLOW:   interval_q[0]  <= cfg_data_i[INTV_W-1:0];
        CFG_INTERVAL_MEDIUM: interval_q[1]  <= cfg_data_i[INTV_W-1:0];
        CFG_INTERVAL_FAST:   interval_q[2]  <= cfg_data_i[INTV_W-1:0];
        CFG_DIVIDER_SLOW:    divider_q[0]   <= cfg_data_i[DIV_W-1:0];
        CFG_DIVIDER_MEDIUM:  divider_q[1]   <= cfg_data_i[DIV_W-1:0];
        CFG_DIVIDER_FAST:    divider_q[2]   <= cfg_data_i[DIV_W-1:0];
        CFG_PAN_INTERVAL:    pan_interval_q <= cfg_data_i[INTV_W-1:0];
        CFG_PROFILE_LOCKOUT: lockout_q      <= cfg_data_i[INTV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    el_prof   = time_us_i - last_prof_q;
    profile_d = profile_q;
    last_prof_d = last_prof_q;
    handled_d = handled_q;
    if (profile_button_i && !handled_q && (el_prof > TIME_BITS'(lockout_q))) begin
      case (profile_q)
        PROFILE_SLOW:   profile_d = PROFILE_MEDIUM;
        PROFILE_MEDIUM: profile_d = PROFILE_FAST;
        default:        profile_d = PROFILE_SLOW;
      endcase
      last_prof_d = time_us_i;
      handled_d   = 1'b1;
    end
    if (!profile_button_i) begin
      handled_d = 1'b0;
    end

    case (profile_d)
      PROFILE_SLOW: begin
        div_sel  = divider_q[0];
        intv_sel = interval_q[0];
      end
      PROFILE_MEDIUM: begin
        div_sel  = divider_q[1];
        intv_sel = interval_q[1];
      end
      default: begin
        div_sel  = divider_q[2];
        intv_sel = interval_q[2];
      end
    endcase

    cx    = {1'b0, joystick_x_i} - Centre;
    cy    = {1'b0, joystick_y_i} - Centre;
    mag_x = cx[ADC_BITS] ? ADC_BITS'(-cx) : cx[ADC_BITS-1:0];
    mag_y = cy[ADC_BITS] ? ADC_BITS'(-cy) : cy[ADC_BITS-1:0];
    hit_y = (CmpW'(mag_y) >= CmpW'(DEADZONE)) && (CmpW'(mag_y) >= CmpW'(div_sel));
    hit_x = (CmpW'(mag_x) >= CmpW'(DEADZONE)) && (CmpW'(mag_x) >= CmpW'(PAN_DIVIDER));
    step_y = !hit_y ? STEP_ZERO : (cy[ADC_BITS] ? STEP_NEG : STEP_POS);
    step_x = !hit_x ? STEP_ZERO : (cx[ADC_BITS] ? STEP_POS : STEP_NEG);

    el_wheel       = time_us_i - last_wheel_q;
    el_pan         = time_us_i - last_pan_q;
    raw_buttons    = {right_button_i, left_button_i};
    last_wheel_d   = last_wheel_q;
    last_pan_d     = last_pan_q;
    sent_buttons_d = sent_buttons_q;
    sent_wheel_d   = sent_wheel_q;
    sent_pan_d     = sent_pan_q;
    wheel_d        = STEP_ZERO;
    pan_d          = STEP_ZERO;
    send_d         = 1'b0;
    buttons_d      = 2'b00;
    fire_d         = '0;
    if (host_ready_i) begin
      fire_d    = macro_buttons_i & ~macro_prev_q;
      buttons_d = raw_buttons;
      if ((step_y != STEP_ZERO) && (el_wheel > TIME_BITS'(intv_sel))) begin
        wheel_d      = step_y;
        last_wheel_d = time_us_i;
      end
      if ((step_x != STEP_ZERO) && (el_pan > TIME_BITS'(pan_interval_q))) begin
        pan_d      = step_x;
        last_pan_d = time_us_i;
      end
      if ((raw_buttons != sent_buttons_q) || (wheel_d != sent_wheel_q) ||
          (pan_d != sent_pan_q)) begin
        send_d         = 1'b1;
        sent_buttons_d = raw_buttons;
        sent_wheel_d   = wheel_d;
        sent_pan_d     = pan_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      profile_q      <= PROFILE_SLOW;
      handled_q      <= 1'b0;
      last_prof_q    <= '0;
      macro_prev_q   <= '0;
      last_wheel_q   <= '0;
      last_pan_q     <= '0;
      sent_buttons_q <= 2'b00;
      sent_wheel_q   <= STEP_ZERO;
      sent_pan_q     <= STEP_ZERO;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        profile_q      <= profile_d;
        handled_q      <= handled_d;
        last_prof_q    <= last_prof_d;
        macro_prev_q   <= macro_buttons_i;
        last_wheel_q   <= last_wheel_d;
        last_pan_q     <= last_pan_d;
        sent_buttons_q <= sent_buttons_d;
        sent_wheel_q   <= sent_wheel_d;
        sent_pan_q     <= sent_pan_d;
        out_valid_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      send_q     <= send_d;
      buttons_q  <= buttons_d;
      wheel_q    <= wheel_d;
      pan_q      <= pan_d;
      fire_q     <= fire_d;
      prof_out_q <= profile_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign report_send_o    = send_q;
  assign report_buttons_o = buttons_q;
  assign report_wheel_o   = $signed(wheel_q);
  assign report_pan_o     = $signed(pan_q);
  assign macro_fire_o     = fire_q;
  assign active_profile_o = prof_out_q;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for joystick_scroll_hid_conditioner: random and directed samples,
// an in-bench report predictor, and in/out idling with back-pressure.
// Depends on jshc_pkg and the conditioner RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jshc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int ADC_CENTRE     = 2048;
  localparam int MAX_SHOWN      = 10;

  typedef enum int {SET_ZERO, SET_MAX, SET_RANDOM} setting_e;

  typedef struct packed {
    logic        prof;
    logic        left;
    logic        right;
    logic [3:0]  macros;
    logic [11:0] jx;
    logic [11:0] jy;
    logic [31:0] t;
    logic        ready;
  } sample_t;

  typedef struct packed {
    logic              send;
    logic [1:0]        buttons;
    logic signed [1:0] wheel;
    logic signed [1:0] pan;
    logic [3:0]        fire;
    logic [1:0]        profile;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        profile_button_i = 1'b0;
  logic        left_button_i = 1'b0;
  logic        right_button_i = 1'b0;
  logic [3:0]  macro_buttons_i = '0;
  logic [11:0] joystick_x_i = '0;
  logic [11:0] joystick_y_i = '0;
  logic [31:0] time_us_i = '0;
  logic        host_ready_i = 1'b0;

  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              report_send_o;
  logic [1:0]        report_buttons_o;
  logic signed [1:0] report_wheel_o;
  logic signed [1:0] report_pan_o;
  logic [3:0]        macro_fire_o;
  logic [1:0]        active_profile_o;

  // predictor copy of registers and state
  logic [INTV_W-1:0] intv_r [3];
  logic [DIV_W-1:0]  div_r [3];
  logic [INTV_W-1:0] pan_intv_r;
  logic [INTV_W-1:0] lockout_r;
  profile_e          prof_idx;
  logic              prof_handled;
  logic [31:0]       last_prof_t;
  logic [3:0]        macro_prev;
  logic [31:0]       last_wheel_t;
  logic [31:0]       last_pan_t;
  logic [1:0]        sent_buttons;
  logic signed [1:0] sent_wheel;
  logic signed [1:0] sent_pan;

  sample_t sample_q [$];
  report_t report_q [$];
  sample_t offered_sample;

  int  err_cnt = 0;
  int  in_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  hold_asked = 0;
  int  hold_taken = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  logic [31:0] now_us = '0;
  bit          prof_lvl, left_lvl, right_lvl;
  logic [3:0]  macro_lvl = '0;

  joystick_scroll_hid_conditioner i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .profile_button_i (profile_button_i),
    .left_button_i    (left_button_i),
    .right_button_i   (right_button_i),
    .macro_buttons_i  (macro_buttons_i),
    .joystick_x_i     (joystick_x_i),
    .joystick_y_i     (joystick_y_i),
    .time_us_i        (time_us_i),
    .host_ready_i     (host_ready_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .report_send_o    (report_send_o),
    .report_buttons_o (report_buttons_o),
    .report_wheel_o   (report_wheel_o),
    .report_pan_o     (report_pan_o),
    .macro_fire_o     (macro_fire_o),
    .active_profile_o (active_profile_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int axis_step(logic [11:0] raw, logic [11:0] divider);
    int c;
    int q;
    c = int'({20'd0, raw}) - ADC_CENTRE;
    if (c > -int'(DEADZONE) && c < int'(DEADZONE)) return 0;
    q = c / ((divider == 12'd0) ? 1 : int'({20'd0, divider}));
    if (q > 1) q = 1;
    if (q < -1) q = -1;
    return q;
  endfunction

  function automatic report_t predict_report(sample_t s);
    report_t    r;
    logic [1:0] btn;
    int         step_y;
    int         step_x;
    r = '0;
    btn = {s.right, s.left};
    if (s.prof && !prof_handled && (s.t - last_prof_t) > {8'd0, lockout_r}) begin
      prof_idx = (prof_idx == PROFILE_FAST) ? PROFILE_SLOW : profile_e'(prof_idx + 2'd1);
      last_prof_t = s.t;
      prof_handled = 1'b1;
    end
    if (!s.prof) prof_handled = 1'b0;
    if (s.ready) r.fire = s.macros & ~macro_prev;
    macro_prev = s.macros;
    step_y = axis_step(s.jy, div_r[prof_idx]);
    step_x = -axis_step(s.jx, 12'(PAN_DIVIDER));
    if (s.ready) begin
      if (step_y != 0 && (s.t - last_wheel_t) > {8'd0, intv_r[prof_idx]}) begin
        r.wheel = step_y[1:0];
        last_wheel_t = s.t;
      end
      if (step_x != 0 && (s.t - last_pan_t) > {8'd0, pan_intv_r}) begin
        r.pan = step_x[1:0];
        last_pan_t = s.t;
      end
      if (btn != sent_buttons || r.wheel != sent_wheel || r.pan != sent_pan) begin
        r.send = 1'b1;
        sent_buttons = btn;
        sent_wheel = r.wheel;
        sent_pan = r.pan;
      end
      r.buttons = btn;
    end
    r.profile = prof_idx;
    return r;
  endfunction

  // driver: present items from sample_q, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) report_q.push_back(predict_report(offered_sample));
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap != 0) begin
          in_gap = in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          offered_sample = sample_q.pop_front();
          profile_button_i <= offered_sample.prof;
          left_button_i    <= offered_sample.left;
          right_button_i   <= offered_sample.right;
          macro_buttons_i  <= offered_sample.macros;
          joystick_x_i     <= offered_sample.jx;
          joystick_y_i     <= offered_sample.jy;
          time_us_i        <= offered_sample.t;
          host_ready_i     <= offered_sample.ready;
          in_valid_i       <= 1'b1;
          if (idle_on && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 12);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check reports, drive output stall
  always @(posedge clk_i or negedge rst_ni) begin
    report_t got;
    report_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {report_send_o, report_buttons_o, report_wheel_o, report_pan_o,
               macro_fire_o, active_profile_o};
        if (report_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN) $display("report with no sample pending: %p", got);
        end else begin
          want = report_q.pop_front();
          if (got.send !== want.send || got.buttons !== want.buttons ||
              got.wheel !== want.wheel || got.pan !== want.pan ||
              got.fire !== want.fire || got.profile !== want.profile) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display("report mismatch at %0t: expected %p, got %p", $realtime, want, got);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_taken != hold_asked) begin
        hold_taken++;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_on && $urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic add_sample(bit pb, bit lb, bit rb, logic [3:0] mac, logic [11:0] jx,
                            logic [11:0] jy, logic [31:0] dt, bit rdy);
    now_us = now_us + dt;
    sample_q.push_back('{prof: pb, left: lb, right: rb, macros: mac, jx: jx, jy: jy,
                         t: now_us, ready: rdy});
  endtask

  function automatic logic [11:0] rand_axis();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      1:       return 12'(ADC_CENTRE - 12 + $urandom_range(0, 24));
      2:       return 12'($urandom);
      default: return 12'(ADC_CENTRE - 1500 + $urandom_range(0, 3000));
    endcase
  endfunction

  task automatic run_random(int count);
    logic [31:0] dt;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) prof_lvl = !prof_lvl;
      if ($urandom_range(0, 4) == 0) left_lvl = !left_lvl;
      if ($urandom_range(0, 4) == 0) right_lvl = !right_lvl;
      if ($urandom_range(0, 2) == 0) macro_lvl = macro_lvl ^ 4'($urandom);
      case ($urandom_range(0, 31))
        0:       dt = $urandom;
        1:       dt = '0;
        2, 3:    dt = $urandom_range(0, 400000);
        default: dt = $urandom_range(0, 70000);
      endcase
      add_sample(prof_lvl, left_lvl, right_lvl, macro_lvl, rand_axis(), rand_axis(), dt,
                 $urandom_range(0, 7) != 0);
    end
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || report_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_INTERVAL_SLOW:   intv_r[PROFILE_SLOW] = data;
      CFG_INTERVAL_MEDIUM: intv_r[PROFILE_MEDIUM] = data;
      CFG_INTERVAL_FAST:   intv_r[PROFILE_FAST] = data;
      CFG_DIVIDER_SLOW:    div_r[PROFILE_SLOW] = data[DIV_W-1:0];
      CFG_DIVIDER_MEDIUM:  div_r[PROFILE_MEDIUM] = data[DIV_W-1:0];
      CFG_DIVIDER_FAST:    div_r[PROFILE_FAST] = data[DIV_W-1:0];
      CFG_PAN_INTERVAL:    pan_intv_r = data;
      CFG_PROFILE_LOCKOUT: lockout_r = data;
      default: ;
    endcase
  endtask

  task automatic configure(setting_e mode);
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
    wait_drained();
    repeat (2) @(negedge clk_i);
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      case (mode)
        SET_ZERO: data = '0;
        SET_MAX:  data = '1;
        default: begin
          if (idx inside {CFG_DIVIDER_SLOW, CFG_DIVIDER_MEDIUM, CFG_DIVIDER_FAST})
            data = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 2100));
          else
            data = $urandom_range(0, 250000);
        end
      endcase
      write_reg(idx, data);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    intv_r[PROFILE_SLOW]   = INTERVAL_SLOW_RST;
    intv_r[PROFILE_MEDIUM] = INTERVAL_MEDIUM_RST;
    intv_r[PROFILE_FAST]   = INTERVAL_FAST_RST;
    div_r[PROFILE_SLOW]    = DIVIDER_SLOW_RST;
    div_r[PROFILE_MEDIUM]  = DIVIDER_MEDIUM_RST;
    div_r[PROFILE_FAST]    = DIVIDER_FAST_RST;
    pan_intv_r   = PAN_INTERVAL_RST;
    lockout_r    = PROFILE_LOCKOUT_RST;
    prof_idx     = PROFILE_SLOW;
    prof_handled = 1'b0;
    last_prof_t  = '0;
    macro_prev   = '0;
    last_wheel_t = '0;
    last_pan_t   = '0;
    sent_buttons = '0;
    sent_wheel   = '0;
    sent_pan     = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // host not ready, macro history, buttons
    add_sample(0, 0, 0, 4'h0, 12'd2048, 12'd2048, 1000, 0);
    add_sample(0, 1, 1, 4'hF, 12'd2048, 12'd2048, 1000, 0);
    add_sample(0, 0, 0, 4'hF, 12'd2048, 12'd2048, 1000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd2048, 12'd2048, 1000, 1);
    add_sample(0, 1, 0, 4'hF, 12'd2048, 12'd2048, 1000, 1);
    add_sample(0, 1, 1, 4'h5, 12'd2048, 12'd2048, 1000, 1);
    add_sample(0, 0, 0, 4'hA, 12'd2048, 12'd2048, 1000, 1);
    // axis extremes, deadzone edges, rate limit
    add_sample(0, 0, 0, 4'h0, 12'd2048, 12'd4095, 300000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd2048, 12'd0, 300000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd2048, 12'd2057, 300000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd2048, 12'd2038, 300000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd0, 12'd2048, 300000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd4095, 12'd2048, 300000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd4095, 12'd4095, 10, 1);
    // profile press, hold, lockout reject, late accept, wrap to slow
    add_sample(1, 0, 0, 4'h0, 12'd2048, 12'd2048, 300000, 1);
    add_sample(1, 0, 0, 4'h0, 12'd2048, 12'd2048, 300000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd2048, 12'd2048, 10, 1);
    add_sample(1, 0, 0, 4'h0, 12'd2048, 12'd2048, 10, 1);
    add_sample(1, 0, 0, 4'h0, 12'd2048, 12'd2048, 300000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd2048, 12'd2048, 10, 1);
    add_sample(1, 0, 0, 4'h0, 12'd2048, 12'd2048, 300000, 1);
    // timestamp wrap
    add_sample(0, 0, 0, 4'h0, 12'd0, 12'd4095, 32'hFFFF_FFF0 - now_us, 1);
    add_sample(0, 0, 0, 4'h0, 12'd0, 12'd4095, 250000, 1);
    add_sample(0, 0, 0, 4'h0, 12'd0, 12'd4095, 5, 1);
    run_random(175);

    configure(SET_ZERO);
    run_random(200);
    configure(SET_MAX);
    run_random(200);
    configure(SET_RANDOM);
    hold_asked++;
    run_random(200);
    configure(SET_RANDOM);
    run_random(200);
    configure(SET_RANDOM);
    run_random(200);

    wait_drained();
    idle_on = 1'b0;
    configure(SET_RANDOM);
    run_random(200);

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
